/* src/swm_pkg.sv */
// Package for the sliding window maximum scale tracker.
// Holds field widths, register indexes and shared types; no dependencies.
package swm_pkg;

   localparam int SCALE_W              = 32;
   localparam int WLEN_W               = 7;
   localparam int TOL_W                = 16;
   localparam int CSR_DATA_W           = 16;
   localparam int CSR_ADDR_W           = 2;
   localparam int WINDOW_DEPTH_DEFAULT = 64;
   localparam int WLEN_RESET           = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LENGTH   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH_TOLERANCE = CSR_ADDR_W'(1);

   typedef logic [SCALE_W-1:0] scale_type;
   typedef logic [WLEN_W-1:0]  wlen_type;
   typedef logic [TOL_W-1:0]   tol_type;

endpackage

/* src/swm_if.sv */
// Valid/ready channel interfaces for the scale tracker's input and result words.
// Depends on swm_pkg for the payload type.
interface swm_req_if;
   import swm_pkg::*;
   logic      valid;
   logic      ready;
   scale_type new_scale;
   modport source (output valid, output new_scale, input ready);
   modport sink   (input valid, input new_scale, output ready);
endinterface

interface swm_rsp_if;
   import swm_pkg::*;
   logic      valid;
   logic      ready;
   scale_type window_max;
   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

/* src/swm_cell.sv */
// One storage cell of the scale ring; shifts its scale to the left neighbor.
// Depends on swm_pkg for the scale type.
module swm_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  swm_pkg::scale_type  shift_in,
   output swm_pkg::scale_type  value_out
);
   import swm_pkg::*;

   scale_type scale_ff;
   scale_type scale_in;

   // Keep the held scale unless the ring rotates.
   assign scale_in  = shift_en ? shift_in : scale_ff;
   assign value_out = scale_ff;

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
   end

endmodule

/* src/sliding_window_max_scale_tracker.sv */
// Top level of the sliding window maximum scale tracker.
// Depends on swm_pkg, the swm_req_if / swm_rsp_if interfaces and swm_cell.
//
// Usage:
//   A word on req_chan carries one Q16.16 scale. For each accepted word the
//   block returns one word on rsp_chan holding the maximum over the last
//   window_length scales. The CSR port writes window_length (index 0, which
//   also restarts the window) and match_tolerance (index 1). The user must
//   write them only while idle; the block itself does not enforce this.
//   The scale ring is a chain of WINDOW_DEPTH cells that rotates once per
//   word. An accepted word goes through a full rotation in the scan state,
//   then the decide state loads the result once the output register is free;
//   the next word is taken only once the block is idle again. During the
//   rotation the head cell reads the evicted entry, writes the new scale and
//   feeds the running maximum compare, one entry per cycle.
//   The result sits in an output register; a new word is accepted while it
//   waits, and the block holds its next result until the receiver takes the
//   pending one.
//   Reset (synchronous, active high) empties the window, clears the maximum
//   and sets window_length to 64 and match_tolerance to zero.
module sliding_window_max_scale_tracker #(
   parameter int WINDOW_DEPTH = swm_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   swm_req_if.sink                           req_chan,
   swm_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [swm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import swm_pkg::*;

   // Slot indexes need SLOT_W bits; counts up to the depth need CNT_W bits.
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int EXT_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   // Control and configuration state.
   logic [1:0]       state_ff, state_in;
   wlen_type         window_length_ff, window_length_in;
   tol_type          match_tolerance_ff, match_tolerance_in;
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [CNT_W-1:0] filled_count_ff, filled_count_in;
   scale_type        kept_max_ff, kept_max_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-word working registers; no reset needed.
   scale_type         cur_ff, cur_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              evict_valid_ff, evict_valid_in;
   scale_type         evicted_ff, evicted_in;
   scale_type         run_max_ff, run_max_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   scale_type         rsp_data_ff, rsp_data_in;

   // Cell chain.
   scale_type cell_q [WINDOW_DEPTH];
   scale_type feed_value;
   logic      shift_en;

   logic [EXT_W-1:0] wl_ext;
   logic [CNT_W-1:0] eff_window;
   logic [CNT_W-1:0] slot_eff;
   logic [CNT_W-1:0] fill_eff;
   logic [CNT_W-1:0] slot_next;
   logic             req_accept;
   logic             rsp_free;
   logic             rescan_hit;
   scale_type        distance;
   scale_type        best;

   // Clamp the configured window length to the range 1..WINDOW_DEPTH.
   always_comb begin
      wl_ext = EXT_W'(window_length_ff);
      if (wl_ext == '0) begin
         eff_window = CNT_W'(1);
      end else if (wl_ext > EXT_W'(WINDOW_DEPTH)) begin
         eff_window = CNT_W'(WINDOW_DEPTH);
      end else begin
         eff_window = CNT_W'(wl_ext);
      end
   end

   // A shrunk window may leave the write slot or fill count out of range.
   assign slot_eff  = (CNT_W'(write_slot_ff) >= eff_window) ? '0 : CNT_W'(write_slot_ff);
   assign fill_eff  = (filled_count_ff > eff_window) ? eff_window : filled_count_ff;
   assign slot_next = slot_eff + CNT_W'(1);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // The ring rotates one cell to the left per scan cycle. The head cell holds
   // entry pos_ff; the new scale replaces it when pos_ff is the write slot.
   assign shift_en   = (state_ff == ST_SCAN);
   assign feed_value = (pos_ff == slot_ff) ? cur_ff : cell_q[0];

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
         if (gi == WINDOW_DEPTH - 1) begin : g_tail
            swm_cell u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .shift_in  (feed_value),
               .value_out (cell_q[gi])
            );
         end else begin : g_body
            swm_cell u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .shift_in  (cell_q[gi+1]),
               .value_out (cell_q[gi])
            );
         end
      end
   endgenerate

   // Decision: a larger new scale wins outright; otherwise a rescan result
   // replaces the maximum only when a written entry close to it was evicted.
   always_comb begin
      distance   = (evicted_ff > kept_max_ff) ? (evicted_ff - kept_max_ff)
                                              : (kept_max_ff - evicted_ff);
      rescan_hit = evict_valid_ff && (distance <= SCALE_W'(match_tolerance_ff));
      if (cur_ff > kept_max_ff) begin
         best = cur_ff;
      end else if (rescan_hit) begin
         best = run_max_ff;
      end else begin
         best = kept_max_ff;
      end
   end

   always_comb begin
      state_in           = state_ff;
      window_length_in   = window_length_ff;
      match_tolerance_in = match_tolerance_ff;
      write_slot_in      = write_slot_ff;
      filled_count_in    = filled_count_ff;
      kept_max_in        = kept_max_ff;
      rsp_valid_in       = rsp_valid_ff;
      cur_in             = cur_ff;
      slot_in            = slot_ff;
      evict_valid_in     = evict_valid_ff;
      evicted_in         = evicted_ff;
      run_max_in         = run_max_ff;
      pos_in             = pos_ff;
      rsp_data_in        = rsp_data_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cur_in         = req_chan.new_scale;
               slot_in        = SLOT_W'(slot_eff);
               evict_valid_in = slot_eff < fill_eff;
               evicted_in     = '0;
               filled_count_in = (fill_eff < eff_window) ? fill_eff + CNT_W'(1) : fill_eff;
               write_slot_in  = (slot_next >= eff_window) ? '0 : SLOT_W'(slot_next);
               run_max_in     = '0;
               pos_in         = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pos_ff == slot_ff) begin
               evicted_in = cell_q[0];
            end
            // Only filled entries take part in the maximum.
            if ((CNT_W'(pos_ff) < filled_count_ff) && (feed_value > run_max_ff)) begin
               run_max_in = feed_value;
            end
            if (pos_ff == SLOT_W'(WINDOW_DEPTH - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               pos_in = pos_ff + SLOT_W'(1);
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               kept_max_in  = best;
               rsp_data_in  = best;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes are to arrive only while idle; the block itself does not
      // enforce this. A window length write restarts the window.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_length_in = csr_wdata[WLEN_W-1:0];
               write_slot_in    = '0;
               filled_count_in  = '0;
               kept_max_in      = '0;
            end
            CSR_MATCH_TOLERANCE: begin
               match_tolerance_in = csr_wdata[TOL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         window_length_ff   <= WLEN_W'(WLEN_RESET);
         match_tolerance_ff <= '0;
         write_slot_ff      <= '0;
         filled_count_ff    <= '0;
         kept_max_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         window_length_ff   <= window_length_in;
         match_tolerance_ff <= match_tolerance_in;
         write_slot_ff      <= write_slot_in;
         filled_count_ff    <= filled_count_in;
         kept_max_ff        <= kept_max_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      slot_ff        <= slot_in;
      evict_valid_ff <= evict_valid_in;
      evicted_ff     <= evicted_in;
      run_max_ff     <= run_max_in;
      pos_ff         <= pos_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.window_max = rsp_data_ff;

   // A result only appears at the end of the decision step.
   a_rsp_from_decide : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
      else $error("result raised outside the decision step");

   // The fill count never exceeds the ring depth.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      filled_count_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("fill count beyond ring depth");

   // The scan state is not left before a full rotation has completed.
   a_accept_after_rotation : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && (pos_ff != SLOT_W'(WINDOW_DEPTH - 1)) |=> (state_ff == ST_SCAN))
      else $error("scan left before a full rotation");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sliding window maximum scale tracker.
// Depends on swm_pkg, the swm_req_if / swm_rsp_if channel interfaces and the
// top level; it runs directed cases first and then random traffic.
`timescale 1ns / 100ps

module testbench;
   import swm_pkg::*;

   localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT;

   // The longest gap between two accepted words is one full pass plus the
   // longest stall on either side, so a quiet stretch as long as QUIET_LIMIT
   // can only mean a hang.
   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = WINDOW_DEPTH + 10;

   // Indexes past the end of the register list; writes there are dropped.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LOW  = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HIGH = CSR_ADDR_W'(3);

   // Shapes of scale sequences used by the random traffic.
   typedef enum int {
      PAT_RANDOM,
      PAT_SMALL,
      PAT_FALLING,
      PAT_NEAR_MAX,
      PAT_REPEAT
   } scale_pattern_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   swm_req_if req_if ();
   swm_rsp_if rsp_if ();

   sliding_window_max_scale_tracker #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state. It mirrors the scale ring, the write pointer, the
   // fill level and the kept maximum, plus both registers.
   // ------------------------------------------------------------------
   scale_type   ring_copy [WINDOW_DEPTH];
   int unsigned next_slot;
   int unsigned filled;
   scale_type   kept_max;
   wlen_type    window_reg;
   tol_type     tolerance_reg;

   // Expected window maxima, oldest first.
   scale_type   pending_max_q [$];
   scale_type   expected_max;
   int unsigned mismatches;

   // Idle controls for each side; turned off for some stretches on purpose.
   bit          sender_gaps_on;
   bit          rsp_stalls_on;
   int unsigned rsp_stall_left;
   int unsigned quiet_cycles;

   // Writing the window length starts the window over. The ring contents
   // stay, but with the fill level at zero none of them is read again.
   function automatic void restart_window_copy();
      next_slot = 0;
      filled    = 0;
      kept_max  = '0;
   endfunction

   // Computes the maximum that the block reports for one new scale, and
   // advances the predictor state exactly as the block does.
   function automatic scale_type track_window_max(input scale_type scale);
      int unsigned span;
      int unsigned slot;
      int unsigned fill;
      int unsigned i;
      bit          evicted_live;
      scale_type   evicted;
      scale_type   best;
      scale_type   gap;
      span = window_reg;
      // A window length of zero behaves as one; above the depth it saturates.
      if (span < 1) begin
         span = 1;
      end
      if (span > WINDOW_DEPTH) begin
         span = WINDOW_DEPTH;
      end
      slot = (next_slot >= span) ? 0 : next_slot;
      fill = (filled > span) ? span : filled;
      // Only a slot that has been written can trigger a rescan when evicted.
      evicted_live = (slot < fill);
      evicted = evicted_live ? ring_copy[slot] : '0;
      ring_copy[slot] = scale;
      if (fill < span) begin
         fill = fill + 1;
      end
      best = kept_max;
      if (scale > best) begin
         best = scale;
      end else if (evicted_live) begin
         // Absolute difference, taken without wraparound.
         gap = (evicted > best) ? evicted - best : best - evicted;
         if (gap <= scale_type'(tolerance_reg)) begin
            best = '0;
            for (i = 0; i < fill; i++) begin
               if (ring_copy[i] > best) begin
                  best = ring_copy[i];
               end
            end
         end
      end
      kept_max  = best;
      filled    = fill;
      next_slot = (slot + 1 >= span) ? 0 : slot + 1;
      return best;
   endfunction

   // Stall lengths: most are short, now and then a long one is drawn.
   function automatic int unsigned pick_stall();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(20, 60);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic int unsigned pick_sender_gap();
      if (!sender_gaps_on || $urandom_range(0, 9) < 6) begin
         return 0;
      end
      return pick_stall();
   endfunction

   // ------------------------------------------------------------------
   // Shared stimulus tasks. Every task is entered and left right after a
   // rising edge, so each one drives the next cycle's inputs.
   // ------------------------------------------------------------------

   // Offers one scale word, waits for it to be taken, records the expected
   // maximum and then holds off for the given number of cycles.
   task automatic send_scale(input scale_type scale, input int unsigned gap);
      // A configuration write left on the port ends as traffic resumes.
      csr_wr_en         <= 1'b0;
      req_if.valid      <= 1'b1;
      req_if.new_scale  <= scale;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      pending_max_q.push_back(track_window_max(scale));
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected word has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_max_q.size() != 0);
   endtask

   // One register write. Write enable stays high so that back to back
   // writes need no idle cycle; the next word sent lowers it.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_WINDOW_LENGTH) begin
         window_reg = wlen_type'(data);
         restart_window_copy();
      end else if (index == CSR_MATCH_TOLERANCE) begin
         tolerance_reg = data;
      end
   endtask

   // ------------------------------------------------------------------
   // Test tasks.
   // ------------------------------------------------------------------

   // Reset values: a window of 64 with exact matching. The scale extremes go
   // through first, and each bit of the field is set and cleared.
   task automatic test_reset_window();
      send_scale(32'h0000_0000, pick_sender_gap());
      send_scale(32'h0000_0001, pick_sender_gap());
      send_scale(32'hFFFF_FFFF, pick_sender_gap());
      send_scale(32'h5555_5555, pick_sender_gap());
      send_scale(32'hAAAA_AAAA, pick_sender_gap());
      send_scale(32'h8000_0000, pick_sender_gap());
      send_scale(32'h0001_0000, pick_sender_gap());
      drain_results();
   endtask

   // A written length of zero acts as a window of one, so every result is
   // the scale just sent; the upper data bits are dropped by the field.
   task automatic test_window_of_one();
      write_csr(CSR_WINDOW_LENGTH, 16'hFF80);
      send_scale(32'h0000_0100, pick_sender_gap());
      send_scale(32'h0000_0050, pick_sender_gap());
      send_scale(32'h0000_0001, pick_sender_gap());
      drain_results();
   endtask

   // A length above the depth saturates to the full window. The window also
   // restarts, so the stale maximum of the last test must not show through.
   task automatic test_window_saturation();
      write_csr(CSR_WINDOW_LENGTH, 16'h007F);
      send_scale(32'h0000_0010, pick_sender_gap());
      send_scale(32'h0000_0008, pick_sender_gap());
      drain_results();
   endtask

   // Rescan rules in a window of three: an evicted maximum within the
   // widest tolerance forces a rescan, then a narrow tolerance is tried
   // where the evicted value sits just inside and just outside of it.
   task automatic test_rescan_tolerance();
      write_csr(CSR_WINDOW_LENGTH, 16'd3);
      write_csr(CSR_MATCH_TOLERANCE, 16'hFFFF);
      send_scale(32'd100, pick_sender_gap());
      send_scale(32'd40, pick_sender_gap());
      send_scale(32'd30, pick_sender_gap());
      send_scale(32'd20, pick_sender_gap());
      drain_results();
      write_csr(CSR_MATCH_TOLERANCE, 16'd5);
      send_scale(32'd35, pick_sender_gap());
      send_scale(32'd31, pick_sender_gap());
      send_scale(32'd38, pick_sender_gap());
      send_scale(32'd10, pick_sender_gap());
      send_scale(32'd10, pick_sender_gap());
      drain_results();
   endtask

   // Writes to indexes past the register list must change nothing.
   task automatic test_spare_indexes();
      write_csr(CSR_SPARE_LOW, 16'hFFFF);
      write_csr(CSR_SPARE_HIGH, 16'h0001);
      send_scale(32'd7, pick_sender_gap());
      send_scale(32'd9, pick_sender_gap());
      drain_results();
   endtask

   // Random traffic under one setting. Scales come in short runs of one
   // shape: plain random words, tiny values that collide often, falling
   // ramps that push the maximum out of the window, values just under the
   // kept maximum, and repeats. Halfway through, the sender waits for
   // every outstanding result before it goes on.
   task automatic test_random_traffic(input logic [CSR_DATA_W-1:0] length_word,
                                      input logic [CSR_DATA_W-1:0] tolerance_word,
                                      input bit with_idling,
                                      input int unsigned word_count);
      int unsigned       sent;
      int unsigned       run_left;
      int unsigned       margin;
      scale_pattern_type pattern;
      scale_type         held;
      scale_type         ramp_step;
      scale_type         scale;
      sent           = 0;
      run_left       = 0;
      pattern        = PAT_RANDOM;
      held           = '0;
      ramp_step      = '0;
      sender_gaps_on = with_idling;
      rsp_stalls_on  = with_idling;
      write_csr(CSR_WINDOW_LENGTH, length_word);
      write_csr(CSR_MATCH_TOLERANCE, tolerance_word);
      while (sent < word_count) begin
         if (run_left == 0) begin
            pattern   = scale_pattern_type'($urandom_range(0, 4));
            run_left  = $urandom_range(1, 16);
            held      = $urandom;
            ramp_step = $urandom_range(1, 4096);
         end
         case (pattern)
            PAT_SMALL: begin
               scale = $urandom_range(0, 7);
            end
            PAT_FALLING: begin
               scale = held;
               held  = (held > ramp_step) ? held - ramp_step : $urandom;
            end
            PAT_NEAR_MAX: begin
               margin = int'(tolerance_reg) + 2;
               scale  = scale_type'($urandom_range(0, margin));
               scale  = (kept_max >= scale) ? kept_max - scale : kept_max;
            end
            PAT_REPEAT: begin
               scale = held;
            end
            default: begin
               scale = $urandom;
            end
         endcase
         send_scale(scale, pick_sender_gap());
         run_left = run_left - 1;
         sent     = sent + 1;
         if (sent == word_count / 2) begin
            drain_results();
         end
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure and the in-order check.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 9) < 2) begin
         rsp_if.ready   <= 1'b0;
         rsp_stall_left <= pick_stall() - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Each word taken on the result channel is matched against the oldest
   // expected maximum. A word with nothing expected is a failure as well.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_max_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h",
                     $time, rsp_if.window_max);
            mismatches++;
         end else begin
            expected_max = pending_max_q.pop_front();
            if (rsp_if.window_max !== expected_max) begin
               $display("%0t: window_max mismatch, expected %h, actual %h",
                        $time, expected_max, rsp_if.window_max);
               mismatches++;
            end
         end
      end
   end

   // The watchdog restarts on any transfer or register write and ends the
   // run if the block goes quiet for too long.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.new_scale = '0;
      rsp_if.ready     = 1'b0;
      rsp_stall_left   = 0;
      quiet_cycles     = 0;
      mismatches       = 0;
      sender_gaps_on   = 1'b1;
      rsp_stalls_on    = 1'b1;
      window_reg       = wlen_type'(WLEN_RESET);
      tolerance_reg    = '0;
      restart_window_copy();
      foreach (ring_copy[i]) begin
         ring_copy[i] = '0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_window_of_one();
      test_window_saturation();
      test_rescan_tolerance();
      test_spare_indexes();

      // Random phases: the first runs with no idling at all, the others
      // cover the length and tolerance extremes plus random settings.
      test_random_traffic(16'd64, 16'd0, 1'b0, 150);
      test_random_traffic(16'd1, 16'hFFFF, 1'b1, 150);
      test_random_traffic(16'd2, 16'($urandom_range(0, 65535)), 1'b1, 150);
      test_random_traffic(16'($urandom_range(3, 63)), 16'd0, 1'b1, 150);
      test_random_traffic(16'hFFFF, 16'($urandom_range(0, 65535)), 1'b1, 150);
      test_random_traffic(16'd0, 16'($urandom_range(0, 16)), 1'b1, 150);
      test_random_traffic(16'($urandom_range(1, 64)), 16'($urandom_range(0, 64)),
                          1'b1, 150);

      // Nothing is outstanding now; give the block one more full pass to
      // show any stray result word before the verdict.
      csr_wr_en <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_max_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
